// ----- src/lts_pkg.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler package
// Shared field widths, request and result codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned PID_W = 16;
  localparam int unsigned CNT_W = 13;
  localparam int unsigned TKT_W = 12;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TAKE = 2'd0,
    CMD_FREE = 2'd1,
    CMD_DRAW = 2'd2
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOROOM = 2'd1,
    ST_MISS   = 2'd2
  } status_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic loop_start;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/lts_req_if.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler request channel
// Valid/ready channel carrying one take, free or draw request.
// ----------------------------------------------------------------------------
interface lts_req_if;

  logic                       valid;
  logic                       ready;
  logic [lts_pkg::CMD_W-1:0]  command;
  logic [lts_pkg::PID_W-1:0]  task_pid;
  logic [lts_pkg::CNT_W-1:0]  ticket_count;
  logic [lts_pkg::TKT_W-1:0]  first_ticket;
  logic [lts_pkg::TKT_W-1:0]  drawn_number;

  modport source (
    output valid, command, task_pid, ticket_count, first_ticket, drawn_number,
    input  ready
  );

  modport sink (
    input  valid, command, task_pid, ticket_count, first_ticket, drawn_number,
    output ready
  );

endinterface

// ----- src/lts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface lts_rsp_if;

  logic                      valid;
  logic                      ready;
  logic [lts_pkg::ST_W-1:0]  status;
  logic [lts_pkg::TKT_W-1:0] granted_first;
  logic [lts_pkg::PID_W-1:0] winner_pid;

  modport source (
    output valid, status, granted_first, winner_pid,
    input  ready
  );

  modport sink (
    input  valid, status, granted_first, winner_pid,
    output ready
  );

endinterface

// ----- src/lts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler controller
// Sequences request accept, the per-ticket write loop and result hand-off.
// ----------------------------------------------------------------------------
module lts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lts_pkg::dp_stat_t stat_i,
  output lts_pkg::ctl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOP = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.loop_start ? S_LOOP : S_FIN;
        end
      end
      S_LOOP: begin
        if (stat_i.last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.step   = (state_q == S_LOOP);
  assign cmd_o.load   = (state_q == S_FIN) && stat_i.out_free;

endmodule

// ----- src/lts_datapath.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler datapath
// Owner/valid table, issue counter, run address counter and result register.
// ----------------------------------------------------------------------------
module lts_datapath #(
  parameter int unsigned TICKETS  = 4096,
  parameter int unsigned PID_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lts_pkg::ctl_cmd_t          cmd_i,
  output lts_pkg::dp_stat_t          stat_o,
  input  logic [lts_pkg::CMD_W-1:0]  command_i,
  input  logic [lts_pkg::PID_W-1:0]  task_pid_i,
  input  logic [lts_pkg::CNT_W-1:0]  ticket_count_i,
  input  logic [lts_pkg::TKT_W-1:0]  first_ticket_i,
  input  logic [lts_pkg::TKT_W-1:0]  drawn_number_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [lts_pkg::ST_W-1:0]   status_o,
  output logic [lts_pkg::TKT_W-1:0]  granted_first_o,
  output logic [lts_pkg::PID_W-1:0]  winner_pid_o
);

  localparam int unsigned IW = $clog2(TICKETS);
  localparam int unsigned NW = $clog2(TICKETS + 1);
  localparam int unsigned AW = (NW > lts_pkg::CNT_W) ? NW : lts_pkg::CNT_W;

  // entry: valid bit above owner id
  logic [PID_BITS:0] mem_q [TICKETS];

  logic [NW-1:0]                next_q;
  logic [lts_pkg::CMD_W-1:0]    cmd_q;
  logic [PID_BITS-1:0]          pid_q;
  logic [lts_pkg::CNT_W-1:0]    cnt_q;
  logic [AW:0]                  addr_q;
  logic [AW-1:0]                drawn_q;
  lts_pkg::status_e             st_q;
  logic [lts_pkg::TKT_W-1:0]    gr_q;
  logic [PID_BITS:0]            rdata_q;

  logic                         out_valid_q;
  lts_pkg::status_e             status_q;
  logic [lts_pkg::TKT_W-1:0]    granted_q;
  logic [lts_pkg::PID_W-1:0]    winner_q;

  logic [AW-1:0]                next_ext;
  logic [AW-1:0]                cnt_ext;
  logic [AW:0]                  sum;
  logic                         fits;
  logic                         is_take;
  logic                         is_free;
  logic                         take_ok;
  logic [PID_BITS+15:0]         pid_wide;
  logic [PID_BITS+15:0]         win_wide;
  logic                         in_range;
  logic                         hit;
  lts_pkg::status_e             res_status;
  logic [lts_pkg::PID_W-1:0]    res_winner;

  assign next_ext = AW'(next_q);
  assign cnt_ext  = AW'(ticket_count_i);
  assign sum      = (AW+1)'(next_ext) + (AW+1)'(cnt_ext);
  assign fits     = (sum <= (AW+1)'(TICKETS));
  assign is_take  = (command_i == lts_pkg::CMD_TAKE);
  assign is_free  = (command_i == lts_pkg::CMD_FREE);
  assign take_ok  = is_take && fits;
  assign pid_wide = {{PID_BITS{1'b0}}, task_pid_i};
  assign in_range = (addr_q < (AW+1)'(TICKETS));

  assign stat_o.loop_start = (ticket_count_i != '0) && (take_ok || is_free);
  assign stat_o.last       = (cnt_q == lts_pkg::CNT_W'(1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // table: one write per in-range loop step, one read at accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && in_range) begin
      mem_q[addr_q[IW-1:0]] <= {(cmd_q == lts_pkg::CMD_TAKE), pid_q};
    end
    if (cmd_i.accept) begin
      rdata_q <= mem_q[IW'(drawn_number_i)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
    end else if (cmd_i.accept && take_ok) begin
      next_q <= sum[NW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= command_i;
      pid_q   <= pid_wide[PID_BITS-1:0];
      cnt_q   <= ticket_count_i;
      addr_q  <= is_take ? (AW+1)'(next_ext) : (AW+1)'(first_ticket_i);
      drawn_q <= AW'(drawn_number_i);
      st_q    <= (is_take && !fits) ? lts_pkg::ST_NOROOM : lts_pkg::ST_OK;
      gr_q    <= take_ok ? next_ext[lts_pkg::TKT_W-1:0] : '0;
    end else if (cmd_i.step) begin
      addr_q <= addr_q + (AW+1)'(1);
      cnt_q  <= cnt_q - lts_pkg::CNT_W'(1);
    end
  end

  // entries at or above the issue counter were never granted since reset
  assign hit      = (drawn_q < next_ext) && rdata_q[PID_BITS];
  assign win_wide = {16'b0, rdata_q[PID_BITS-1:0]};

  always_comb begin
    res_status = st_q;
    res_winner = '0;
    if (cmd_q == lts_pkg::CMD_DRAW) begin
      res_status = hit ? lts_pkg::ST_OK : lts_pkg::ST_MISS;
      res_winner = hit ? win_wide[lts_pkg::PID_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q  <= res_status;
      granted_q <= gr_q;
      winner_q  <= res_winner;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_first_o = granted_q;
  assign winner_pid_o    = winner_q;

endmodule

// ----- src/lottery_ticket_scheduler.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler
// Ticket table for lottery scheduling: take, free and draw requests.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req_i    in         valid/ready        command, task_pid, ticket_count,
//                                         first_ticket, drawn_number
//  rsp_o    out        valid/ready        status, granted_first, winner_pid
//
//  Draw, refused take, zero-count take/free, unused code: no table loop.
//  Take or free of n tickets: one loop step per cycle, writing in-range tickets.
//  The single-port owner/valid table sets the loop; one request is in work.
//  Reset clears the issue counter only; entries at or above it read as not
//  valid, so no clearing pass runs. A request is taken while the previous
//  result still waits; completion holds until the result register frees.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler #(
  parameter int unsigned TICKETS  = 4096,
  parameter int unsigned PID_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lts_req_if.sink   req_i,
  lts_rsp_if.source rsp_o
);

  lts_pkg::ctl_cmd_t ctl_cmd;
  lts_pkg::dp_stat_t dp_stat;

  lts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  lts_datapath #(
    .TICKETS  (TICKETS),
    .PID_BITS (PID_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctl_cmd),
    .stat_o          (dp_stat),
    .command_i       (req_i.command),
    .task_pid_i      (req_i.task_pid),
    .ticket_count_i  (req_i.ticket_count),
    .first_ticket_i  (req_i.first_ticket),
    .drawn_number_i  (req_i.drawn_number),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .status_o        (rsp_o.status),
    .granted_first_o (rsp_o.granted_first),
    .winner_pid_o    (rsp_o.winner_pid)
  );

  a_no_accept_in_loop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !ctl_cmd.step && !ctl_cmd.load)
    else $error("request taken while table loop or result load active");

  a_draw_two_cycles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.command == lts_pkg::CMD_DRAW) && !rsp_o.valid)
    |-> ##2 (rsp_o.valid && (rsp_o.status != lts_pkg::ST_NOROOM)))
    else $error("draw result not delivered in two cycles");

  a_empty_take_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.command == lts_pkg::CMD_TAKE)
     && (req_i.ticket_count == '0) && !rsp_o.valid)
    |-> ##2 (rsp_o.valid && (rsp_o.status == lts_pkg::ST_OK)))
    else $error("zero-count take not answered ok");

endmodule
